@@ src/scfs_pkg.sv @@
// Package for the serial command frame scanner.
// Holds the frame constants, byte codes, result and push types.
// No dependencies; used by every module of the block.
package scfs_pkg;

   // frame geometry
   localparam int FRAME_BYTES  = 64;
   localparam int LAST_CHANNEL = 6;
   localparam int POS_W        = $clog2(FRAME_BYTES);

   // result queue depth (holds two words per byte plus slack)
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // byte codes
   localparam logic [7:0] BYTE_NEXT_CHAN = 8'h00;
   localparam logic [7:0] BYTE_PAD       = 8'hFF;
   localparam logic [7:0] BYTE_END_RESP  = 8'hFE;
   localparam logic [7:0] BYTE_PAD_B4    = 8'hB4;
   localparam logic [7:0] BYTE_PAD_56    = 8'h56;
   localparam logic [7:0] BYTE_PAD_B8    = 8'hB8;
   localparam logic [7:0] TOP_BITS_MASK  = 8'hC0;
   localparam logic [7:0] LEN_MASK       = 8'h3F;

   // channel limits
   localparam logic [2:0] CHAN_MAX  = 3'd7;
   localparam logic [2:0] CHAN_LAST = 3'(LAST_CHANNEL);
   localparam logic [2:0] CHAN_CART = 3'd4;

   // scan modes
   localparam logic MODE_CMD  = 1'b0;
   localparam logic MODE_RESP = 1'b1;

   // result kinds
   localparam logic KIND_DESC   = 1'b0;
   localparam logic KIND_NOTICE = 1'b1;

   // targets
   localparam logic [1:0] TGT_PORT      = 2'd0;
   localparam logic [1:0] TGT_CART      = 2'd1;
   localparam logic [1:0] TGT_UNHANDLED = 2'd2;

   // end causes
   localparam logic [1:0] CAUSE_NONE      = 2'd0;
   localparam logic [1:0] CAUSE_MARKER    = 2'd1;
   localparam logic [1:0] CAUSE_CHAN_LIM  = 2'd2;
   localparam logic [1:0] CAUSE_EXHAUSTED = 2'd3;

   typedef struct packed {
      logic       kind;
      logic [2:0] channel;
      logic [5:0] cmd_offset;
      logic [5:0] send_len;
      logic [5:0] recv_len;
      logic [1:0] target;
      logic [1:0] end_cause;
      logic       last;
   } result_type;

   // words produced by one byte, in delivery order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

@@ src/scfs_core.sv @@
// Scanner state and per-byte decode for the command frame scanner.
// Depends on scfs_pkg; produces up to two result words per byte.
module scfs_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [7:0]         data_byte,
   input  logic               frame_start,
   input  logic               scan_mode,
   output scfs_pkg::push_type push
);

   typedef enum logic [1:0] {
      PH_SCAN,
      PH_RECV,
      PH_SKIP,
      PH_DONE
   } phase_type;

   logic [scfs_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [2:0]                 chan_ff, chan_in;
   phase_type                  phase_ff, phase_in;
   logic [6:0]                 skip_ff, skip_in;
   logic [5:0]                 hsend_ff, hsend_in;
   logic [5:0]                 hoff_ff, hoff_in;

   logic [scfs_pkg::POS_W+5:0] pos_ext;
   logic [5:0]                 off;
   logic [5:0]                 rlen;
   logic                       desc_v;
   logic                       note_v;
   scfs_pkg::result_type       desc;
   scfs_pkg::result_type       note;

   // low six bits of the current position
   assign pos_ext = {6'b0, (frame_start ? '0 : pos_ff)};
   assign off     = pos_ext[5:0];
   assign rlen    = data_byte[5:0] & scfs_pkg::LEN_MASK[5:0];

   // per-byte decode
   always_comb begin
      phase_type ph;
      logic [2:0] ch;
      logic [6:0] sk;
      logic [scfs_pkg::POS_W-1:0] pos;

      ph  = phase_ff;
      ch  = chan_ff;
      sk  = skip_ff;
      pos = pos_ff;
      if (frame_start) begin
         ph  = PH_SCAN;
         ch  = 3'd0;
         sk  = 7'd0;
         pos = '0;
      end
      hsend_in = hsend_ff;
      hoff_in  = hoff_ff;
      desc_v   = 1'b0;
      note_v   = 1'b0;

      desc            = '0;
      desc.kind       = scfs_pkg::KIND_DESC;
      desc.cmd_offset = hoff_ff;
      desc.send_len   = hsend_ff;
      desc.recv_len   = rlen;
      desc.channel    = ch;
      if (ch < scfs_pkg::CHAN_CART) begin
         desc.target = scfs_pkg::TGT_PORT;
      end else if (ch == scfs_pkg::CHAN_CART) begin
         desc.target = scfs_pkg::TGT_CART;
      end else begin
         desc.target = scfs_pkg::TGT_UNHANDLED;
      end
      desc.end_cause = scfs_pkg::CAUSE_NONE;

      note            = '0;
      note.kind       = scfs_pkg::KIND_NOTICE;
      note.cmd_offset = off;
      note.end_cause  = scfs_pkg::CAUSE_MARKER;
      note.last       = 1'b1;

      case (ph)
         PH_SCAN: begin
            if (data_byte == scfs_pkg::BYTE_NEXT_CHAN) begin
               if (ch < scfs_pkg::CHAN_MAX) begin
                  ch = ch + 3'd1;
               end
               if (ch > scfs_pkg::CHAN_LAST) begin
                  note_v         = 1'b1;
                  note.end_cause = scfs_pkg::CAUSE_CHAN_LIM;
                  ph             = PH_DONE;
               end
            end else if (data_byte == scfs_pkg::BYTE_PAD) begin
               // padding
            end else if (scan_mode == scfs_pkg::MODE_RESP &&
                         data_byte == scfs_pkg::BYTE_END_RESP) begin
               note_v = 1'b1;
               ph     = PH_DONE;
            end else if (scan_mode == scfs_pkg::MODE_RESP &&
                         (data_byte == scfs_pkg::BYTE_PAD_B4 ||
                          data_byte == scfs_pkg::BYTE_PAD_56 ||
                          data_byte == scfs_pkg::BYTE_PAD_B8)) begin
               // padding in the response pass
            end else if ((data_byte & scfs_pkg::TOP_BITS_MASK) == 8'h00) begin
               hsend_in = data_byte[5:0];
               hoff_in  = off;
               ph       = PH_RECV;
            end else begin
               note_v = 1'b1;
               ph     = PH_DONE;
            end
         end
         PH_RECV: begin
            desc_v = 1'b1;
            if (ch < scfs_pkg::CHAN_MAX) begin
               ch = ch + 3'd1;
            end
            sk = {1'b0, hsend_ff} + {1'b0, rlen};
            ph = (sk != 7'd0) ? PH_SKIP : PH_SCAN;
         end
         PH_SKIP: begin
            if (sk != 7'd0) begin
               sk = sk - 7'd1;
            end
            if (sk == 7'd0) begin
               ph = PH_SCAN;
            end
         end
         default: begin
            // frame over: wait for the next frame start
         end
      endcase

      // last byte of the frame
      if (pos >= scfs_pkg::POS_W'(scfs_pkg::FRAME_BYTES - 1)) begin
         if (ph != PH_DONE) begin
            note_v         = 1'b1;
            note.end_cause = scfs_pkg::CAUSE_EXHAUSTED;
            ph             = PH_DONE;
         end
         pos_in = '0;
      end else begin
         pos_in = pos + 1'b1;
      end

      note.channel = ch;
      desc.last    = !note_v;
      chan_in      = ch;
      skip_in      = sk;
      phase_in     = ph;
   end

   // words in delivery order: descriptor first, then notice
   always_comb begin
      push.count  = {1'b0, desc_v} + {1'b0, note_v};
      push.first  = desc_v ? desc : note;
      push.second = note;
   end

   // scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         chan_ff  <= 3'd0;
         phase_ff <= PH_SCAN;
         skip_ff  <= 7'd0;
         hsend_ff <= 6'd0;
         hoff_ff  <= 6'd0;
      end else if (advance) begin
         pos_ff   <= pos_in;
         chan_ff  <= chan_in;
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
         hsend_ff <= hsend_in;
         hoff_ff  <= hoff_in;
      end
   end

endmodule

@@ src/scfs_queue.sv @@
// Result queue for the command frame scanner: takes up to two words a
// cycle and hands out one. Depends on scfs_pkg.
module scfs_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           wr_count,
   input  scfs_pkg::result_type wr_first,
   input  scfs_pkg::result_type wr_second,
   output logic                 room_two,
   output logic                 rd_valid,
   input  logic                 rd_ready,
   output scfs_pkg::result_type rd_word
);

   scfs_pkg::result_type          mem_ff [scfs_pkg::QUEUE_DEPTH];
   logic [scfs_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [scfs_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [scfs_pkg::QCNT_W-1:0]   count_ff, count_in;
   logic [scfs_pkg::QPTR_W-1:0]   wr_ptr_next;
   logic                          pop;

   assign rd_valid    = count_ff != '0;
   assign rd_word     = mem_ff[rd_ptr_ff];
   assign pop         = rd_valid && rd_ready;
   assign room_two    = count_ff <= scfs_pkg::QCNT_W'(scfs_pkg::QUEUE_DEPTH - 2);
   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + scfs_pkg::QPTR_W'(wr_count);
      rd_ptr_in = rd_ptr_ff + scfs_pkg::QPTR_W'(pop);
      count_in  = count_ff + scfs_pkg::QCNT_W'(wr_count) - scfs_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (wr_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= wr_first;
      end
      if (wr_count == 2'd2) begin
         mem_ff[wr_ptr_next] <= wr_second;
      end
   end

endmodule

@@ src/serial_command_frame_scanner_top.sv @@
// Top level of the serial command frame scanner.
// Depends on scfs_pkg, scfs_core and scfs_queue.
//
// Usage:
//   req_ channel: one frame byte per word, req_tdata = data byte,
//   req_tuser = frame start (offset 0 of a new frame).
//   rsp_ channel: command descriptors and end of frame notices;
//   rsp_tuser = kind, rsp_tlast = last word caused by that byte.
//   csr_ port: csr_wen with csr_wdata writes the scan mode
//   (0 command pass, 1 response pass) at the clock edge.
// A taken byte waits in the input register; its decoded words are written
//   into the result queue, which offers them. Throughput: one byte per cycle
//   while the queue has room for two words; a byte at the final offset that
//   finishes a command yields two words. The rate is set by the single decode
//   stage between the input register and the four-word result queue.
// Reset (synchronous, active high) empties the queue, the input register
//   and puts the scan at offset 0, channel 0, command pass.
// When the receiver stalls the queue fills; req_tready drops once fewer
//   than two free slots remain and the input register holds its byte.
module serial_command_frame_scanner_top (
   input  logic        clock,
   input  logic        reset,
   // config
   input  logic        csr_wen,
   input  logic        csr_wdata,
   // byte input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] frame_start
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [2:0] channel, [8:3] cmd_offset, [14:9] send_len,
                                    // [20:15] recv_len, [22:21] target, [24:23] end_cause
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast    // last
);

   logic                 mode_ff, mode_in;
   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff, in_byte_in;
   logic                 in_start_ff, in_start_in;
   logic                 room_two;
   logic                 advance;
   logic                 req_take;
   logic [1:0]           wr_count;
   scfs_pkg::push_type   push;
   scfs_pkg::result_type word;

   assign advance    = in_valid_ff && room_two;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign wr_count   = advance ? push.count : 2'd0;

   // input register and mode register
   always_comb begin
      mode_in     = csr_wen ? csr_wdata : mode_ff;
      in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_byte_in  = req_take ? req_tdata : in_byte_ff;
      in_start_in = req_take ? req_tuser : in_start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= scfs_pkg::MODE_CMD;
         in_valid_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_start_ff <= in_start_in;
   end

   scfs_core u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .data_byte   (in_byte_ff),
      .frame_start (in_start_ff),
      .scan_mode   (mode_ff),
      .push        (push)
   );

   scfs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_count  (wr_count),
      .wr_first  (push.first),
      .wr_second (push.second),
      .room_two  (room_two),
      .rd_valid  (rsp_tvalid),
      .rd_ready  (rsp_tready),
      .rd_word   (word)
   );

   // output packing
   assign rsp_tdata = {7'b0, word.end_cause, word.target, word.recv_len,
                       word.send_len, word.cmd_offset, word.channel};
   assign rsp_tuser = word.kind;
   assign rsp_tlast = word.last;

endmodule

@@ src/scfs_checker.sv @@
// Port-level checks for the serial command frame scanner.
// Depends on scfs_pkg; bound to serial_command_frame_scanner_top below.
module scfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // reset leaves nothing queued and the input side open
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("words offered or input closed after reset");

   // a stalled word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // a notice always closes the words of its byte and carries no lengths
   a_notice_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == scfs_pkg::KIND_NOTICE |->
      rsp_tlast && rsp_tdata[22:9] == 14'd0 &&
      rsp_tdata[24:23] != scfs_pkg::CAUSE_NONE)
      else $error("malformed end of frame notice");

   // a descriptor has no end cause and a known target
   a_desc_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == scfs_pkg::KIND_DESC |->
      rsp_tdata[24:23] == scfs_pkg::CAUSE_NONE &&
      rsp_tdata[22:21] != 2'd3)
      else $error("malformed command descriptor");

endmodule

bind serial_command_frame_scanner_top scfs_checker u_scfs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

@@ tb/tb.sv @@
// Self-checking testbench for serial_command_frame_scanner_top.
// Depends on scfs_pkg and the scanner RTL; a scoreboard class predicts the
// descriptor and notice words for every byte taken and checks the results.
module tb;
   import scfs_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int BYTES_PER_RUN = 90;

   typedef enum logic [1:0] {PH_SCAN, PH_RECV, PH_SKIP, PH_DONE} scan_phase_type;

   // Frame scan predictor plus the store of words still owed by the block
   class frame_scoreboard;
      logic           scan_mode = MODE_CMD;
      int             position = 0;
      logic [2:0]     chan = '0;
      scan_phase_type phase = PH_SCAN;
      logic [6:0]     skip_left = '0;
      logic [5:0]     held_len = '0;
      logic [5:0]     held_off = '0;
      result_type     expected_words[$];
      int             mismatches = 0;

      function void push_word(logic kind, logic [2:0] ch, logic [5:0] off,
                              logic [5:0] sl, logic [5:0] rl, logic [1:0] tg,
                              logic [1:0] cause);
         result_type w;
         w = '0;
         w.kind       = kind;
         w.channel    = ch;
         w.cmd_offset = off;
         w.send_len   = sl;
         w.recv_len   = rl;
         w.target     = tg;
         w.end_cause  = cause;
         expected_words.push_back(w);
      endfunction

      function void end_frame(logic [5:0] off, logic [1:0] cause);
         push_word(KIND_NOTICE, chan, off, '0, '0, TGT_PORT, cause);
         phase = PH_DONE;
      endfunction

      // Predicts the words caused by one accepted byte
      function void note_byte(logic [7:0] b, logic start);
         int         pos;
         int         prior_words;
         logic [5:0] rl;
         logic [1:0] tg;
         if (start) begin
            position  = 0;
            chan      = '0;
            phase     = PH_SCAN;
            skip_left = '0;
         end
         pos         = position;
         prior_words = expected_words.size();
         case (phase)
            PH_SCAN: begin
               if (b == BYTE_NEXT_CHAN) begin
                  if (chan != CHAN_MAX) chan = chan + 3'd1;
                  if (chan > CHAN_LAST) end_frame(pos[5:0], CAUSE_CHAN_LIM);
               end else if (b == BYTE_PAD) begin
                  // padding
               end else if (scan_mode == MODE_RESP && b == BYTE_END_RESP) begin
                  end_frame(pos[5:0], CAUSE_MARKER);
               end else if (scan_mode == MODE_RESP &&
                            (b == BYTE_PAD_B4 || b == BYTE_PAD_56 || b == BYTE_PAD_B8)) begin
                  // response pass padding
               end else if ((b & TOP_BITS_MASK) == 8'h00) begin
                  held_len = b[5:0];
                  held_off = pos[5:0];
                  phase    = PH_RECV;
               end else begin
                  end_frame(pos[5:0], CAUSE_MARKER);
               end
            end
            PH_RECV: begin
               rl = b[5:0];
               if (chan < CHAN_CART)       tg = TGT_PORT;
               else if (chan == CHAN_CART) tg = TGT_CART;
               else                        tg = TGT_UNHANDLED;
               push_word(KIND_DESC, chan, held_off, held_len, rl, tg, CAUSE_NONE);
               if (chan != CHAN_MAX) chan = chan + 3'd1;
               skip_left = 7'(held_len) + 7'(rl);
               phase     = (skip_left != 0) ? PH_SKIP : PH_SCAN;
            end
            PH_SKIP: begin
               if (skip_left != 0) skip_left = skip_left - 7'd1;
               if (skip_left == 0) phase = PH_SCAN;
            end
            default: ;
         endcase
         // frame exhausted at the final offset
         if (pos >= FRAME_BYTES - 1) begin
            if (phase != PH_DONE) end_frame(pos[5:0], CAUSE_EXHAUSTED);
            position = 0;
         end else begin
            position = pos + 1;
         end
         if (expected_words.size() > prior_words)
            expected_words[expected_words.size() - 1].last = 1'b1;
      endfunction

      function void cmp_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_word(logic [31:0] data, logic user, logic lastw);
         result_type w;
         if (expected_words.size() == 0) begin
            $error("result word with nothing outstanding: tdata %h", data);
            mismatches++;
            return;
         end
         w = expected_words.pop_front();
         cmp_field("kind",       w.kind,       user);
         cmp_field("channel",    w.channel,    data[2:0]);
         cmp_field("cmd_offset", w.cmd_offset, data[8:3]);
         cmp_field("send_len",   w.send_len,   data[14:9]);
         cmp_field("recv_len",   w.recv_len,   data[20:15]);
         cmp_field("target",     w.target,     data[22:21]);
         cmp_field("end_cause",  w.end_cause,  data[24:23]);
         cmp_field("last",       w.last,       lastw);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic        csr_wdata = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   frame_scoreboard sb = new;

   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   sent_count = 0;
   int   cycle_count = 0;
   logic cur_mode = MODE_CMD;
   bit   frame_fresh = 1'b0;
   int   frame_pos = 0;

   serial_command_frame_scanner_top u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side: check each accepted word, then stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // offer one byte, idling first at random, and return at the edge it is taken
   task automatic send_byte(logic [7:0] d, logic s);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(d, s);
      sent_count++;
   endtask

   // next byte of the frame being built; frame start on the first if wanted
   task automatic put_byte(logic [7:0] d);
      send_byte(d, frame_fresh);
      frame_fresh = 1'b0;
      frame_pos++;
   endtask

   // let every owed word out plus any byte still in flight
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_scan_mode(logic m);
      wait_drained();
      csr_wen   <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_wen      <= 1'b0;
      sb.scan_mode  = m;
      cur_mode      = m;
   endtask

   // one frame: mostly well-formed command lists, some noise
   task automatic send_random_frame();
      int   style;
      int   roll;
      int   tail_at;
      int   sl;
      int   rl;
      bit   stop;
      logic [7:0] pads[3];
      pads = '{BYTE_PAD_B4, BYTE_PAD_56, BYTE_PAD_B8};
      style       = $urandom_range(0, 99);
      frame_fresh = ($urandom_range(0, 9) != 0);
      frame_pos   = 0;
      stop        = 1'b0;
      if (style < 15) begin
         repeat ($urandom_range(1, 80))
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
         return;
      end
      // tail frames park a command on the last few offsets
      if (style >= 80) begin
         tail_at = $urandom_range(58, FRAME_BYTES - 1);
         while (frame_pos < tail_at) put_byte(BYTE_PAD);
      end
      while (frame_pos < FRAME_BYTES && !stop) begin
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            put_byte(BYTE_NEXT_CHAN);
         end else if (roll < 22) begin
            put_byte(BYTE_PAD);
         end else if (roll < 27 && cur_mode == MODE_RESP) begin
            put_byte(pads[$urandom_range(0, 2)]);
         end else if (roll < 31) begin
            if (cur_mode == MODE_RESP && $urandom_range(0, 9) < 6)
               put_byte(BYTE_END_RESP);
            else if (cur_mode == MODE_RESP)
               put_byte(8'($urandom_range(8'hC0, 8'hFD)));
            else
               put_byte(8'($urandom_range(8'h40, 8'hFE)));
            stop = 1'b1;
         end else begin
            sl = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 4);
            rl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4);
            put_byte(8'(sl));
            put_byte({2'($urandom_range(0, 3)), 6'(rl)});
            for (int i = 0; i < sl + rl && frame_pos < FRAME_BYTES; i++)
               put_byte(8'($urandom_range(0, 255)));
         end
      end
      repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: command pass, no frame start after reset
      send_byte(8'h01, 1'b0);            // send length at offset 0
      send_byte(8'hC2, 1'b0);            // receive length, top bits masked off
      send_byte(8'h00, 1'b0);            // data area is skipped whatever it holds
      send_byte(8'hFF, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(BYTE_NEXT_CHAN, 1'b0);
      send_byte(BYTE_PAD, 1'b0);
      send_byte(BYTE_NEXT_CHAN, 1'b0);
      send_byte(BYTE_NEXT_CHAN, 1'b0);   // now on the cartridge channel
      send_byte(8'h02, 1'b0);
      send_byte(8'h40, 1'b0);            // zero receive length
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(BYTE_NEXT_CHAN, 1'b0);
      send_byte(BYTE_NEXT_CHAN, 1'b0);   // channel passes the limit
      send_byte(8'h55, 1'b0);            // ignored after the end
      send_byte(8'h80, 1'b1);            // frame start, bad byte in command pass
      send_byte(8'hFE, 1'b1);            // bad byte in command pass too
      write_scan_mode(MODE_RESP);
      send_byte(BYTE_PAD_B4, 1'b1);
      send_byte(BYTE_PAD_56, 1'b0);
      send_byte(BYTE_PAD_B8, 1'b0);
      send_byte(BYTE_PAD, 1'b0);
      send_byte(BYTE_END_RESP, 1'b0);    // end marker in response pass
      send_byte(8'hC5, 1'b1);            // bad byte in response pass

      // random: four idling patterns, each in both modes
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
         endcase
         for (int k = 0; k < 2; k++) begin
            write_scan_mode(k == 0 ? MODE_CMD : MODE_RESP);
            sent_count = 0;
            while (sent_count < BYTES_PER_RUN) send_random_frame();
         end
      end

      wait_drained();
      if (sb.mismatches == 0 && sb.expected_words.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
